[hw/rtl/nlk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nlk_pkg;

    // result and scan width: one spare bit above the widest start value
    localparam int OUT_BITS = 63;
    localparam int K_W      = 6;
    localparam int CNT_W    = 6;
    // sums of counts and positions (up to 125)
    localparam int SUM_W    = 7;
    // popcount grouping for the prefix count
    localparam int GRP_SIZE = 8;
    localparam int GRP_CNT  = 8;
    localparam int LOC_W    = 4;
    localparam int PAD_BITS = GRP_SIZE * GRP_CNT;

    typedef logic [OUT_BITS-1:0]                       word_t;
    typedef logic [K_W-1:0]                            count_t;
    typedef logic [OUT_BITS-1:0][CNT_W-1:0]            cnt_vec_t;
    typedef logic [GRP_CNT-1:0][GRP_SIZE-1:0][LOC_W-1:0] loc_vec_t;

endpackage

`default_nettype wire

[hw/rtl/nlk_count.sv]
`timescale 1ns / 1ps
`default_nettype none

// two stages: group-local prefix popcounts, then ones above every bit
module nlk_count
    import nlk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  word_t    n_in,
    input  count_t   k_in,
    output logic     out_valid,
    input  logic     out_ready,
    output word_t    n_out,
    output count_t   k_out,
    output cnt_vec_t above_out
);

    logic [PAD_BITS-1:0] n_pad;
    loc_vec_t            loc_next;
    loc_vec_t            loc_reg;
    word_t               n1_reg;
    count_t              k1_reg;
    logic                v1_reg;
    cnt_vec_t            above_next;
    cnt_vec_t            above_reg;
    word_t               n2_reg;
    count_t              k2_reg;
    logic                v2_reg;
    logic                en1;
    logic                en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign n_pad = {{(PAD_BITS - OUT_BITS){1'b0}}, n_in};

    // inclusive running count inside each group of eight bits
    always_comb
    begin
        logic [LOC_W-1:0] acc;
        acc = '0;
        for (int g = 0; g < GRP_CNT; g++)
        begin
            acc = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                acc = acc + LOC_W'(n_pad[g*GRP_SIZE + j]);
                loc_next[g][j] = acc;
            end
        end
    end

    // group bases, total, and ones strictly above each position
    always_comb
    begin
        logic [SUM_W-1:0]              run;
        logic [GRP_CNT-1:0][SUM_W-1:0] base;
        logic [SUM_W-1:0]              incl;
        run  = '0;
        base = '0;
        incl = '0;
        for (int g = 0; g < GRP_CNT; g++)
        begin
            base[g] = run;
            run     = run + SUM_W'(loc_reg[g][GRP_SIZE-1]);
        end
        for (int i = 0; i < OUT_BITS; i++)
        begin
            incl = base[i / GRP_SIZE] + SUM_W'(loc_reg[i / GRP_SIZE][i % GRP_SIZE]);
            above_next[i] = CNT_W'(run - incl);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            loc_reg <= loc_next;
            n1_reg  <= n_in;
            k1_reg  <= k_in;
        end
        if (en2 && v1_reg)
        begin
            above_reg <= above_next;
            n2_reg    <= n1_reg;
            k2_reg    <= k1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign n_out     = n2_reg;
    assign k_out     = k2_reg;
    assign above_out = above_reg;

endmodule

`default_nettype wire

[hw/rtl/nlk_select.sv]
`timescale 1ns / 1ps
`default_nettype none

// two stages: qualifying positions, then lowest one and kept upper bits
module nlk_select
    import nlk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  word_t    n_in,
    input  count_t   k_in,
    input  cnt_vec_t above_in,
    output logic     out_valid,
    input  logic     out_ready,
    output word_t    base_out,
    output word_t    onehot_out,
    output cnt_vec_t rest_out
);

    word_t    q_next;
    cnt_vec_t rest_next;
    word_t    q_reg;
    cnt_vec_t rest3_reg;
    word_t    n3_reg;
    logic     v3_reg;
    word_t    mask_le;
    word_t    onehot;
    word_t    base_reg;
    word_t    onehot_reg;
    cnt_vec_t rest4_reg;
    logic     v4_reg;
    logic     en3;
    logic     en4;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    // bit i qualifies when it is zero and the ones left to place fit below it
    always_comb
    begin
        logic [SUM_W-1:0] need;
        logic [SUM_W-1:0] kk;
        need = '0;
        kk   = SUM_W'(k_in);
        for (int i = 0; i < OUT_BITS; i++)
        begin
            need         = SUM_W'(above_in[i]) + SUM_W'(1);
            q_next[i]    = !n_in[i] && (need <= kk) && (kk <= need + SUM_W'(i));
            rest_next[i] = CNT_W'(k_in) - above_in[i] - CNT_W'(1);
        end
    end

    // bits at and below the lowest qualifying position
    assign mask_le = q_reg ^ (q_reg - OUT_BITS'(1));
    assign onehot  = mask_le & q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                v3_reg <= in_valid;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
        begin
            q_reg     <= q_next;
            rest3_reg <= rest_next;
            n3_reg    <= n_in;
        end
        if (en4 && v3_reg)
        begin
            base_reg   <= (n3_reg & ~mask_le) | onehot;
            onehot_reg <= onehot;
            rest4_reg  <= rest3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign base_out   = base_reg;
    assign onehot_out = onehot_reg;
    assign rest_out   = rest4_reg;

endmodule

`default_nettype wire

[hw/rtl/next_larger_with_k_set_bits.sv]
// Next larger value with k set bits. Each request carries start_value (n) and
// ones_count (k); the response next_value is the smallest integer strictly
// above n with exactly k ones, or zero when k is zero. One request can be
// taken every clock cycle while the output side keeps up; the five register
// stages are a group-local popcount, the ones-above count per bit, the
// per-bit qualify compare, the lowest-set-bit pick (one 63-bit subtract),
// and the final fill of the low ones into the output register. A stall on
// the output side holds the whole pipe in place; empty stages still fill
// while stalled. Only the low VALUE_BITS bits of start_value exist on the
// port; the result is always 63 bits wide because the answer can carry one
// bit past the input.
`timescale 1ns / 1ps
`default_nettype none

module next_larger_with_k_set_bits
    import nlk_pkg::*;
#(
    parameter int VALUE_BITS = 62
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] start_value,
    input  logic [K_W-1:0]        ones_count,
    // response channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_BITS-1:0]   next_value
);

    // n widened to the scan width; the spare top bit is always zero, so a
    // qualifying position always exists for any nonzero k
    word_t    n_ext;

    // count stages -> select stages
    logic     cnt_valid;
    logic     cnt_ready;
    word_t    cnt_n;
    count_t   cnt_k;
    cnt_vec_t cnt_above;

    // select stages -> output stage
    logic     sel_valid;
    logic     sel_ready;
    word_t    sel_base;
    word_t    sel_onehot;
    cnt_vec_t sel_rest;

    // output stage
    logic [CNT_W-1:0] rest_pick;
    word_t            fill;
    word_t            next_value_reg;
    logic             out_valid_reg;
    logic             en5;

    assign n_ext = {{(OUT_BITS - VALUE_BITS){1'b0}}, start_value};

    nlk_count u_count
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .n_in      (n_ext),
        .k_in      (ones_count),
        .out_valid (cnt_valid),
        .out_ready (cnt_ready),
        .n_out     (cnt_n),
        .k_out     (cnt_k),
        .above_out (cnt_above)
    );

    nlk_select u_select
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cnt_valid),
        .in_ready   (cnt_ready),
        .n_in       (cnt_n),
        .k_in       (cnt_k),
        .above_in   (cnt_above),
        .out_valid  (sel_valid),
        .out_ready  (sel_ready),
        .base_out   (sel_base),
        .onehot_out (sel_onehot),
        .rest_out   (sel_rest)
    );

    // output register advances when empty or when the response is taken
    assign en5       = !out_valid_reg || out_ready;
    assign sel_ready = en5;

    // ones still to place, picked by the one-hot winning position;
    // no winner (k of zero) gives zero here and a zero base
    always_comb
    begin
        rest_pick = '0;
        for (int i = 0; i < OUT_BITS; i++)
        begin
            rest_pick = rest_pick | (sel_rest[i] & {CNT_W{sel_onehot[i]}});
        end
    end

    // thermometer of rest_pick ones at the bottom; rest never exceeds the
    // winning position so it never collides with the set bit
    always_comb
    begin
        for (int j = 0; j < OUT_BITS; j++)
        begin
            fill[j] = (CNT_W'(j) < rest_pick);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en5)
        begin
            out_valid_reg <= sel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5 && sel_valid)
        begin
            next_value_reg <= sel_base | fill;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_value = next_value_reg;

endmodule

`default_nettype wire

[hw/rtl/nlk_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module nlk_checker
    import nlk_pkg::*;
#(
    parameter int VALUE_BITS = 62
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [VALUE_BITS-1:0] start_value,
    input logic [K_W-1:0]        ones_count,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [OUT_BITS-1:0]   next_value
);

    // pending request keeps its payload
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> $stable(start_value) && $stable(ones_count))
        else $error("request payload changed while stalled");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_value))
        else $error("response dropped or changed while stalled");

    // back-pressure only comes from a stalled full output
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready || !out_valid |-> in_ready)
        else $error("request side stalled without output back-pressure");

    // with out_ready held high, an accepted request yields a valid response
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready
        ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("response missing five cycles after request");

endmodule

bind next_larger_with_k_set_bits nlk_checker #(.VALUE_BITS(VALUE_BITS)) u_nlk_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_value (start_value),
    .ones_count  (ones_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .next_value  (next_value)
);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import nlk_pkg::*;

    // the start value port is 62 bits wide at the default parameter
    localparam int START_W = 62;
    // cycles with no request or response moving before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // pipe depth is five stages, so this covers any late stray response
    localparam int DRAIN_CYCLES = 20;
    // random requests per idling phase
    localparam int RANDOM_PER_PHASE = 500;
    localparam int NUM_PROBES = 23;

    // zero is never a legal answer, the block returns it when k is zero
    localparam word_t NO_ANSWER = '0;
    localparam logic [START_W-1:0] ALL_START = '1;

    typedef struct packed {
        logic [START_W-1:0] n;
        count_t             k;
        bit                 typed;
        word_t              value;
    } probe_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [START_W-1:0] start_value = '0;
    count_t             ones_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    word_t              next_value;

    // answers still owed by the block, oldest first
    word_t pending_answers[$];
    int    mismatch_count = 0;
    int    stall_cycles = 0;
    int    src_idle_pct = 0;
    int    snk_idle_pct = 0;

    // directed probes: extremes, the error answer, the power-of-two and
    // mask cases; typed answers only where they are obvious, zero
    // in the typed column means the predictor supplies the answer
    probe_t probes [0:NUM_PROBES-1] = '{
        // zero count gives the error answer, at both ends of n
        {62'd0, 6'd0, 1'b1, NO_ANSWER},
        {ALL_START, 6'd0, 1'b1, NO_ANSWER},
        // from zero: low masks, including the out-of-range count of 63
        {62'd0, 6'd1, 1'b1, 63'd1},
        {62'd0, 6'd62, 1'b1, 63'h3FFF_FFFF_FFFF_FFFF},
        {62'd0, 6'd63, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF},
        // all ones: the answer carries into bit 62
        {ALL_START, 6'd63, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF},
        {ALL_START, 6'd62, 1'b1, 63'h5FFF_FFFF_FFFF_FFFF},
        {ALL_START, 6'd1, 1'b1, 63'h4000_0000_0000_0000},
        // next power of two
        {62'd5, 6'd1, 1'b1, 63'd8},
        // n equals the low mask, then the mask lies above n
        {62'd3, 6'd2, 1'b1, 63'd5},
        {62'd2, 6'd3, 1'b1, 63'd7},
        // only the top input bit set, then a low run of ones
        {62'h2000_0000_0000_0000, 6'd1, 1'b1, 63'h4000_0000_0000_0000},
        {62'h2000_0000_0000_0000, 6'd2, 1'b1, 63'h2000_0000_0000_0001},
        {62'h0000_0000_FFFF_FFFF, 6'd32, 1'b1, 63'h0000_0001_7FFF_FFFF},
        // general cases left to the predictor
        {62'd6, 6'd2, 1'b0, NO_ANSWER},
        {62'h2AAA_AAAA_AAAA_AAAA, 6'd31, 1'b0, NO_ANSWER},
        {62'h1555_5555_5555_5555, 6'd62, 1'b0, NO_ANSWER},
        {62'h3FFF_FFFF_FFFF_FFFE, 6'd61, 1'b0, NO_ANSWER},
        {62'd1, 6'd62, 1'b0, NO_ANSWER},
        {62'h3FFF_FFFF_0000_0000, 6'd40, 1'b0, NO_ANSWER},
        {62'h0000_0000_FFFF_FFFF, 6'd16, 1'b0, NO_ANSWER},
        {62'h2000_0000_0000_0000, 6'd62, 1'b0, NO_ANSWER},
        {62'h1234_5678_9ABC_DEF0, 6'd30, 1'b0, NO_ANSWER}
    };

    next_larger_with_k_set_bits u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_value (start_value),
        .ones_count  (ones_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .next_value  (next_value)
    );

    always #1 clk = ~clk;

    // smallest value above n with exactly k ones: walk the zero bits of n
    // from the bottom, take the first one where the ones above it plus
    // itself leave no more ones than there are bit positions below it
    function automatic word_t next_with_count(logic [START_W-1:0] n, count_t k);
        word_t v;
        word_t upper;
        int    above;
        int    rest;
        v = {1'b0, n};
        if (k == 0)
            return NO_ANSWER;
        for (int i = 0; i < OUT_BITS; i++)
        begin
            if (v[i])
                continue;
            upper = (v >> (i + 1)) << (i + 1);
            above = $countones(upper);
            if (above + 1 > int'(k))
                continue;
            rest = int'(k) - above - 1;
            if (rest > i)
                continue;
            return upper | (word_t'(1) << i) | ((word_t'(1) << rest) - word_t'(1));
        end
        return NO_ANSWER;
    endfunction

    // random start values: uniform, sparse, dense, shifted masks and small
    function automatic logic [START_W-1:0] pick_start_value();
        logic [63:0]        r;
        logic [START_W-1:0] v;
        int                 shape;
        r = {$urandom(), $urandom()};
        shape = $urandom_range(0, 5);
        case (shape)
            0, 1: v = r[START_W-1:0];
            2:
            begin
                v = '0;
                repeat ($urandom_range(1, 4)) v[$urandom_range(0, START_W-1)] = 1'b1;
            end
            3:
            begin
                v = '1;
                repeat ($urandom_range(1, 4)) v[$urandom_range(0, START_W-1)] = 1'b0;
            end
            4:
            begin
                // a run of ones, shifted up so it often sits at the top
                v = (({START_W{1'b0}} | 1'b1) << $urandom_range(1, START_W)) - 1'b1;
                v = v << $urandom_range(0, START_W-1);
            end
            default: v = r[START_W-1:0] >> $urandom_range(40, START_W-1);
        endcase
        return v;
    endfunction

    // counts near the popcount of n hit the mask and carry cases most often
    function automatic count_t pick_count(logic [START_W-1:0] n);
        int c;
        if ($urandom_range(0, 1) == 0)
            return count_t'($urandom_range(0, 63));
        c = $countones(n) + $urandom_range(0, 4) - 2;
        if (c < 0)
            c = 0;
        if (c > 63)
            c = 63;
        return count_t'(c);
    endfunction

    task automatic report_mismatch(input word_t got, input word_t want);
        $display("mismatch at %0t: next_value %h, wanted %h", $realtime, got, want);
        mismatch_count++;
    endtask

    // one request: random idle cycles first, then hold valid until taken
    task automatic send_request(input logic [START_W-1:0] n, input count_t k,
                                input bit typed, input word_t typed_value);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_value <= n;
        ones_count  <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        pending_answers.insert(pending_answers.size(),
                               typed ? typed_value : next_with_count(n, k));
    endtask

    // response side: check what is taken, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch(next_value, 'x);
            else if (next_value !== pending_answers[0])
                report_mismatch(next_value, pending_answers.pop_front());
            else
                void'(pending_answers.pop_front());
        end
        out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [START_W-1:0] n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily, then the reverse, then none
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 63 : 0;
            snk_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 14 : 0;
            if (phase == 0)
            begin
                foreach (probes[i])
                    send_request(probes[i].n, probes[i].k, probes[i].typed, probes[i].value);
            end
            for (int j = 0; j < RANDOM_PER_PHASE; j++)
            begin
                n = pick_start_value();
                send_request(n, pick_count(n), 1'b0, NO_ANSWER);
            end
        end
        in_valid <= 1'b0;

        // the watchdog covers a response that never comes
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
